FILE: src/hru_pkg.sv
// ----------------------------------------------------------------------------
// hru_pkg
// Shared types and constants of the HyperLogLog register update unit.
// ----------------------------------------------------------------------------
package hru_pkg;

  // Default sketch precision: 2^PRECISION registers
  localparam int PRECISION_DEF = 14;

  // Fixed field widths
  localparam int HASH_W = 64;
  localparam int IDX_W  = 14;
  localparam int VAL_W  = 6;
  localparam int CNT_W  = 15;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_MERGE    = 2'd1,
    OP_READ_REG = 2'd2,
    OP_READ_BIN = 2'd3
  } opcode_t;

endpackage

FILE: src/hll_register_update_unit.sv
// ----------------------------------------------------------------------------
// hll_register_update_unit
// Dense HyperLogLog sketch engine: register store, rank update and value
// histogram, with register and histogram-bin reads.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  -------------------------------------------
//  in       in   in_valid / in_stall  opcode, hash_value, reg_index, reg_value,
//                                     bin_index
//  out      out  out_valid/out_stall  changed, target_index, old_value,
//                                     new_value, bin_count
//
//  Sequencing: one beat at a time through a read-modify-write sequencer on two
//  one-port-read / one-port-write memories. A raised register adds the S_HOLD
//  and S_HNEW states for the histogram decrement and increment on the single
//  histogram port.
//  Reset: a clearing pass writes every register to zero and the histogram to
//  bin 0 = 2^PRECISION; in_stall is high throughout.
//  Stalls: the result sits in an output register; a new beat is taken while it
//  waits, and the sequencer only blocks when its next result finds that
//  register still full and stalled.
//
module hll_register_update_unit
  import hru_pkg::*;
#(
  parameter int PRECISION = PRECISION_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [HASH_W-1:0]   hash_value,
  input  logic [IDX_W-1:0]    reg_index,
  input  logic [VAL_W-1:0]    reg_value,
  input  logic [VAL_W-1:0]    bin_index,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                changed,
  output logic [IDX_W-1:0]    target_index,
  output logic [VAL_W-1:0]    old_value,
  output logic [VAL_W-1:0]    new_value,
  output logic [CNT_W-1:0]    bin_count
);

  // Sizes
  localparam int NReg     = 1 << PRECISION;
  localparam int MaxRank  = 65 - PRECISION;
  localparam int NBins    = MaxRank + 1;
  localparam int BinW     = $clog2(NBins);
  localparam int CntW     = PRECISION + 1;   // bin 0 can hold every register
  localparam int ClrDepth = (NReg > NBins) ? NReg : NBins;
  localparam int ClrW     = $clog2(ClrDepth);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RANK  = 6'b000100,
    S_CMP   = 6'b001000,
    S_HOLD  = 6'b010000,
    S_HNEW  = 6'b100000
  } state_t;

  // S_HOLD: old bin read back, decrement; S_HNEW: new bin read back, increment.
  // Result is loaded from S_CMP (no raise) or S_HNEW (raise) into the out reg.

  state_t state, state_next;

  // Memories
  logic [VAL_W-1:0] reg_mem  [NReg];
  logic [CntW-1:0]  hist_mem [NBins];

  logic                 rm_we, rm_re;
  logic [PRECISION-1:0] rm_waddr, rm_raddr;
  logic [VAL_W-1:0]     rm_wdata, reg_q;

  logic                 hm_we, hm_re;
  logic [BinW-1:0]      hm_waddr, hm_raddr;
  logic [CntW-1:0]      hm_wdata, hist_q;

  // Beat context
  opcode_t              op_q;
  logic [HASH_W-1:0]    hash_q;
  logic [PRECISION-1:0] idx_q;
  logic [IDX_W-1:0]     tidx_q;
  logic                 idx_ok_q;
  logic                 bin_ok_q;
  logic [VAL_W-1:0]     val_q;
  logic [VAL_W-1:0]     old_q;
  logic                 chg_q;

  logic [ClrW-1:0]      clr_cnt;

  logic                 in_acc, out_free, raise, load_out;
  opcode_t              in_op;
  logic [PRECISION-1:0] in_addr;
  logic [VAL_W-1:0]     rank;

  // Leading-zero count of a 64-bit word, as eight byte groups then a
  // combine over the groups.
  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [3:0] grp_lz [8];
    logic [7:0] grp_nz;
    logic [6:0] lz;
    logic       found;
    logic       hit;
    for (int g = 0; g < 8; g++) begin
      grp_nz[g] = |x[8*g +: 8];
      grp_lz[g] = 4'd8;
      hit = 1'b0;
      for (int b = 7; b >= 0; b--) begin
        if (!hit && x[8*g + b]) begin
          grp_lz[g] = 4'(7 - b);
          hit = 1'b1;
        end
      end
    end
    lz = '0;
    found = 1'b0;
    for (int g = 7; g >= 0; g--) begin
      if (!found) begin
        lz = lz + 7'(grp_lz[g]);
        found = grp_nz[g];
      end
    end
    return lz;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_op    = opcode_t'(opcode);
  assign in_addr  = (in_op == OP_ADD) ? hash_value[HASH_W-1 -: PRECISION]
                                      : PRECISION'(reg_index);

  // Rank of the hash tail, capped; the low PRECISION bits shifted in are zero
  always_comb begin
    logic [6:0] lz;
    lz = lzc64(hash_q << PRECISION);
    if (int'(lz) >= MaxRank) begin
      rank = VAL_W'(MaxRank);
    end else begin
      rank = VAL_W'(lz + 7'd1);
    end
  end

  assign raise = idx_ok_q && ((op_q == OP_ADD) || (op_q == OP_MERGE)) && (val_q > reg_q);

  // Result goes out of S_CMP when nothing is raised, else after S_HNEW
  assign load_out = out_free &&
                    ((state == S_CMP && !raise) || state == S_HNEW);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == ClrW'(ClrDepth - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_next = S_RANK;
      end
      S_RANK: state_next = S_CMP;
      S_CMP: begin
        if (raise) state_next = S_HOLD;
        else if (out_free) state_next = S_IDLE;
      end
      S_HOLD: state_next = S_HNEW;
      S_HNEW: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Memory port control
  always_comb begin
    rm_we    = 1'b0;
    rm_waddr = idx_q;
    rm_wdata = val_q;
    rm_re    = 1'b0;
    rm_raddr = in_addr;
    hm_we    = 1'b0;
    hm_waddr = BinW'(old_q);
    hm_wdata = hist_q - CntW'(1);
    hm_re    = 1'b0;
    hm_raddr = BinW'(bin_index);
    unique case (state)
      S_CLEAR: begin
        rm_we    = int'(clr_cnt) < NReg;
        rm_waddr = PRECISION'(clr_cnt);
        rm_wdata = '0;
        hm_we    = int'(clr_cnt) < NBins;
        hm_waddr = BinW'(clr_cnt);
        hm_wdata = (clr_cnt == '0) ? CntW'(NReg) : '0;
      end
      S_IDLE: begin
        rm_re = in_acc;
        hm_re = in_acc && (in_op == OP_READ_BIN);
      end
      S_RANK: ;
      S_CMP: begin
        // raise: store the new value, fetch the old value's bin
        rm_we    = raise;
        hm_re    = raise;
        hm_raddr = BinW'(reg_q);
      end
      S_HOLD: begin
        hm_we    = 1'b1;
        hm_re    = 1'b1;
        hm_raddr = BinW'(val_q);
      end
      S_HNEW: begin
        // rewriting the same count while the result waits is harmless
        hm_we    = chg_q;
        hm_waddr = BinW'(val_q);
        hm_wdata = hist_q + CntW'(1);
      end
      default: ;
    endcase
  end

  // Register store
  always_ff @(posedge clk) begin
    if (rm_we) reg_mem[rm_waddr] <= rm_wdata;
    if (rm_re) reg_q <= reg_mem[rm_raddr];
  end

  // Value histogram
  always_ff @(posedge clk) begin
    if (hm_we) hist_mem[hm_waddr] <= hm_wdata;
    if (hm_re) hist_q <= hist_mem[hm_raddr];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + ClrW'(1);
      out_valid <= load_out || (out_valid && out_stall);
    end
  end

  // Beat context
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q     <= in_op;
      hash_q   <= hash_value;
      idx_q    <= in_addr;
      idx_ok_q <= (in_op == OP_ADD) || (int'(reg_index) < NReg);
      bin_ok_q <= int'(bin_index) < NBins;
      val_q    <= (int'(reg_value) > MaxRank) ? VAL_W'(MaxRank) : reg_value;
      unique case (in_op)
        OP_ADD:      tidx_q <= IDX_W'(hash_value[HASH_W-1 -: PRECISION]);
        OP_MERGE:    tidx_q <= reg_index;
        OP_READ_REG: tidx_q <= reg_index;
        OP_READ_BIN: tidx_q <= '0;
        default:     tidx_q <= '0;
      endcase
    end
    if (state == S_RANK && op_q == OP_ADD) val_q <= rank;
    if (state == S_CMP) begin
      chg_q <= raise;
      old_q <= (idx_ok_q && op_q != OP_READ_BIN) ? reg_q : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == S_CMP) begin
        changed   <= 1'b0;
        old_value <= (idx_ok_q && op_q != OP_READ_BIN) ? reg_q : '0;
        new_value <= (idx_ok_q && op_q != OP_READ_BIN) ? reg_q : '0;
      end else begin
        changed   <= chg_q;
        old_value <= old_q;
        new_value <= val_q;
      end
      target_index <= tidx_q;
      bin_count    <= (op_q == OP_READ_BIN && bin_ok_q) ? CNT_W'(hist_q) : '0;
    end
  end

endmodule

FILE: src/hru_checker.sv
// ----------------------------------------------------------------------------
// hru_checker
// Port-level checks of the HyperLogLog register update unit.
// ----------------------------------------------------------------------------
module hru_checker
  import hru_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              changed,
  input logic [IDX_W-1:0]  target_index,
  input logic [VAL_W-1:0]  old_value,
  input logic [VAL_W-1:0]  new_value,
  input logic [CNT_W-1:0]  bin_count
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(changed) &&
      $stable(target_index) && $stable(old_value) && $stable(new_value) &&
      $stable(bin_count))
    else $error("stalled result beat changed");

  // a raise always moves the register up
  a_raise_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && changed |-> new_value > old_value)
    else $error("raise without a larger value");

  a_keep: assert property (@(posedge clk) disable iff (rst)
    out_valid && !changed |-> new_value == old_value)
    else $error("register moved without changed");

  // only a bin read carries a count, and it carries nothing else
  a_bin_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && bin_count != '0 |->
      !changed && target_index == '0 && old_value == '0 && new_value == '0)
    else $error("bin count mixed with register fields");

  // clearing pass blocks input right after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("input open during clearing pass");

endmodule

bind hll_register_update_unit hru_checker u_hru_checker (.*);
